@@ rtl/core/mono_framebuffer_draw_engine_defines.svh @@
// Assertion macros for the drawing engine checker.
// Expects aclk and aresetn in the scope of use.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MFDE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("drawing engine assertion failed");

// next-cycle implication, disabled during reset
`define MFDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("drawing engine assertion failed");

`endif

@@ rtl/core/mfde_pkg.sv @@
// Shared constants, command codes and types of the drawing engine.
// No dependencies.
package mfde_pkg;

    localparam int PANEL_WIDTH  = 800;
    localparam int PANEL_HEIGHT = 480;
    localparam int PIXEL_COUNT  = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int STORE_BYTES  = (PIXEL_COUNT + 7) / 8;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int PIX_W        = $clog2(2047 * PANEL_WIDTH + 2048 + 1);
    localparam int COORD_W      = 13;
    localparam int IDX_W        = 11;

    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_RECT  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ROT_REVERSE = 2'd2;

    localparam logic signed [COORD_W-1:0] BOUND_WIDTH  = COORD_W'(PANEL_WIDTH);
    localparam logic signed [COORD_W-1:0] BOUND_HEIGHT = COORD_W'(PANEL_HEIGHT);

    localparam logic [7:0] BYTE_BLACK = 8'hFF;
    localparam logic [7:0] BYTE_WHITE = 8'h00;

    typedef struct packed {
        logic             hit;
        logic [PIX_W-1:0] pix;
    } pix_res_t;

endpackage

@@ rtl/core/mfde_pixel_unit.sv @@
// Shared pixel unit: clip test and linear pixel index, one registered stage.
// Depends on mfde_pkg.
module mfde_pixel_unit
    import mfde_pkg::*;
(
    input  logic                      aclk,
    input  logic                      rot_odd,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output pix_res_t                  res
);

    logic signed [COORD_W-1:0] bound_w;
    logic signed [COORD_W-1:0] bound_h;
    pix_res_t                  res_next;

    always_comb begin
        bound_w = rot_odd ? BOUND_HEIGHT : BOUND_WIDTH;
        bound_h = rot_odd ? BOUND_WIDTH : BOUND_HEIGHT;
        res_next.hit = (px >= 0) && (px < bound_w) && (py >= 0) && (py < bound_h);
        res_next.pix = PIX_W'(px[IDX_W-1:0])
                     + PIX_W'(py[IDX_W-1:0]) * PIX_W'(PANEL_WIDTH);
    end

    always_ff @(posedge aclk) begin
        res <= res_next;
    end

endmodule

@@ rtl/core/mono_framebuffer_draw_engine.sv @@
// Drawing engine over a one-bit-per-pixel frame store.
// Depends on mfde_pkg and mfde_pixel_unit.
//
// Usage:
//   Requests enter on the s_ channel (valid/ready); each request yields exactly
//   one result on the m_ channel: the addressed byte for a read, zero otherwise.
//   The user writes the rotation register through cfg_wr_en / cfg_wr_data
//   only while idle; the block itself does not enforce this. One request is
//   worked at a time; s_ready is low from acceptance until the result has been
//   handed to the output register. Per request, from acceptance to result ready:
//     fill all      writes every store byte, one store byte written per cycle
//     set pixel     read-modify-write of one byte; read only when clipped
//     fill rectangle read-modify-write per hit pixel; empty writes nothing
//     read byte     one store read; out of range gives zero without a read
//   The pixel rate is set by the shared clip and index multiplier and the
//   single store port, each pixel reading its byte and writing it when it hits.
//   Reset clears the sequencer, the output valid and the rotation; the store
//   itself holds undefined data until written.
//   A stalled receiver holds the result in the output register; a further
//   request is accepted and worked, then waits until the register frees.
module mono_framebuffer_draw_engine
    import mfde_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [11:0] s_x_pos,
    input  logic signed [11:0] s_y_pos,
    input  logic [10:0]        s_rect_width,
    input  logic [10:0]        s_rect_height,
    input  logic               s_white,
    input  logic [15:0]        s_byte_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_read_byte
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_CALC  = 4'd3;
    localparam logic [3:0] ST_ADDR  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_WR    = 4'd6;
    localparam logic [3:0] ST_RADDR = 4'd7;
    localparam logic [3:0] ST_RDATA = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] rotation_reg;

    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_W-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_W-1:0] x_start_reg, x_start_next;
    logic signed [COORD_W-1:0] x_end_reg, x_end_next;
    logic signed [COORD_W-1:0] y_end_reg, y_end_next;
    logic                      white_reg, white_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [7:0]                mask_reg, mask_next;
    logic                      hit_reg, hit_next;
    logic [7:0]                fill_byte_reg, fill_byte_next;
    logic [7:0]                result_reg, result_next;
    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_read_byte_reg, m_read_byte_next;

    logic [7:0]        store [STORE_BYTES];
    logic [7:0]        store_rdata_reg;
    logic              store_we;
    logic [ADDR_W-1:0] store_addr;
    logic [7:0]        store_wdata;

    pix_res_t pix_res;

    logic signed [COORD_W-1:0] x_ext, y_ext, w_ext, h_ext;
    logic signed [COORD_W-1:0] bound_w, bound_h;
    logic signed [COORD_W-1:0] rx_end, ry_end;
    logic [PIX_W-1:0]          pix_eff;
    logic signed [COORD_W-1:0] x_inc;
    logic                      accept;

    mfde_pixel_unit u_pixel (
        .aclk    (aclk),
        .rot_odd (rotation_reg[0]),
        .px      (cur_x_reg),
        .py      (cur_y_reg),
        .res     (pix_res)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;

    always_comb begin
        x_ext   = {s_x_pos[11], s_x_pos};
        y_ext   = {s_y_pos[11], s_y_pos};
        w_ext   = {2'b00, s_rect_width};
        h_ext   = {2'b00, s_rect_height};
        bound_w = rotation_reg[0] ? BOUND_HEIGHT : BOUND_WIDTH;
        bound_h = rotation_reg[0] ? BOUND_WIDTH : BOUND_HEIGHT;
        rx_end  = x_ext + w_ext;
        ry_end  = y_ext + h_ext;
        if (rx_end > bound_w) begin
            rx_end = bound_w;
        end
        if (ry_end > bound_h) begin
            ry_end = bound_h;
        end
        pix_eff = (rotation_reg == ROT_REVERSE)
                ? PIX_W'(PIXEL_COUNT - 1) - pix_res.pix
                : pix_res.pix;
        x_inc   = cur_x_reg + COORD_W'(1);
    end

    always_comb begin
        state_next       = state_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        x_start_next     = x_start_reg;
        x_end_next       = x_end_reg;
        y_end_next       = y_end_reg;
        white_next       = white_reg;
        addr_next        = addr_reg;
        mask_next        = mask_reg;
        hit_next         = hit_reg;
        fill_byte_next   = fill_byte_reg;
        result_next      = result_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_byte_next = m_read_byte_reg;
        store_we         = 1'b0;
        store_addr       = addr_reg;
        store_wdata      = fill_byte_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    white_next  = s_white;
                    result_next = 8'h00;
                    case (s_cmd)
                        CMD_FILL: begin
                            addr_next      = '0;
                            fill_byte_next = s_white ? BYTE_WHITE : BYTE_BLACK;
                            state_next     = ST_FILL;
                        end
                        CMD_PIXEL: begin
                            cur_x_next   = x_ext;
                            cur_y_next   = y_ext;
                            x_start_next = x_ext;
                            x_end_next   = x_ext + COORD_W'(1);
                            y_end_next   = y_ext + COORD_W'(1);
                            state_next   = ST_CHECK;
                        end
                        CMD_RECT: begin
                            cur_x_next   = (x_ext < 0) ? '0 : x_ext;
                            cur_y_next   = (y_ext < 0) ? '0 : y_ext;
                            x_start_next = (x_ext < 0) ? '0 : x_ext;
                            x_end_next   = rx_end;
                            y_end_next   = ry_end;
                            state_next   = ST_CHECK;
                        end
                        default: begin
                            addr_next = ADDR_W'(s_byte_index);
                            if (32'(s_byte_index) < STORE_BYTES) begin
                                state_next = ST_RADDR;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_FILL: begin
                store_we   = 1'b1;
                store_addr = addr_reg;
                if (addr_reg == ADDR_W'(STORE_BYTES - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_CHECK: begin
                if ((cur_x_reg >= x_end_reg) || (cur_y_reg >= y_end_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                hit_next   = pix_res.hit && (pix_res.pix < PIX_W'(PIXEL_COUNT));
                addr_next  = ADDR_W'(pix_eff >> 3);
                mask_next  = 8'h80 >> pix_eff[2:0];
                state_next = ST_RD;
            end
            ST_RD: begin
                store_addr = addr_reg;
                if (hit_reg) begin
                    state_next = ST_WR;
                end else begin
                    if (x_inc >= x_end_reg) begin
                        cur_x_next = x_start_reg;
                        cur_y_next = cur_y_reg + COORD_W'(1);
                    end else begin
                        cur_x_next = x_inc;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_WR: begin
                store_we    = 1'b1;
                store_addr  = addr_reg;
                store_wdata = white_reg ? (store_rdata_reg & ~mask_reg)
                                        : (store_rdata_reg | mask_reg);
                if (x_inc >= x_end_reg) begin
                    cur_x_next = x_start_reg;
                    cur_y_next = cur_y_reg + COORD_W'(1);
                end else begin
                    cur_x_next = x_inc;
                end
                state_next = ST_CHECK;
            end
            ST_RADDR: begin
                store_addr = addr_reg;
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                result_next = store_rdata_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_read_byte_next = result_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            rotation_reg <= 2'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                rotation_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        x_start_reg     <= x_start_next;
        x_end_reg       <= x_end_next;
        y_end_reg       <= y_end_next;
        white_reg       <= white_next;
        addr_reg        <= addr_next;
        mask_reg        <= mask_next;
        hit_reg         <= hit_next;
        fill_byte_reg   <= fill_byte_next;
        result_reg      <= result_next;
        m_read_byte_reg <= m_read_byte_next;
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store[store_addr] <= store_wdata;
        end
        store_rdata_reg <= store[store_addr];
    end

endmodule

@@ rtl/core/mfde_checker.sv @@
// Port-level checker for the drawing engine, bound to the top level.
// Depends on mfde_pkg and mono_framebuffer_draw_engine_defines.svh.
`include "mono_framebuffer_draw_engine_defines.svh"

module mfde_checker
    import mfde_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_cmd,
    input logic [15:0]        s_byte_index,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_read_byte
);

    logic oor_read_free;

    assign oor_read_free = s_valid && s_ready && (s_cmd == CMD_READ)
                        && (32'(s_byte_index) >= STORE_BYTES) && (!m_valid || m_ready);

    `MFDE_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_read_byte))

    `MFDE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    `MFDE_ASSERT_NEXT(a_idle_holds, s_ready && !s_valid, s_ready)

    `MFDE_ASSERT_IMPL(a_read_out_of_range, oor_read_free, ##2 (m_valid && (m_read_byte == 8'h00)))

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);
